// ===== rtl/ppb_pkg.sv =====
// ----------------------------------------------------------------------------
// ppb_pkg
// Types, codes, reset values and saturating arithmetic helpers shared by the
// planar pressure profile binner.
// ----------------------------------------------------------------------------
package ppb_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ATOM  = 2'd1,
		OP_PAIR  = 2'd2,
		OP_EMIT  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_Z_MIN          = 3'd0,
		REG_Z_MAX          = 3'd1,
		REG_Z_PITCH        = 3'd2,
		REG_INV_AREA       = 3'd3,
		REG_INV_BIN_VOLUME = 3'd4,
		REG_UNIT_FACTOR    = 3'd5
	} reg_idx_t;

	localparam logic signed [31:0] RST_Z_MIN          = 32'sd0;
	localparam logic signed [31:0] RST_Z_MAX          = 32'sd4194304;
	localparam logic [30:0]        RST_Z_PITCH        = 31'd65536;
	localparam logic [31:0]        RST_INV_AREA       = 32'd65536;
	localparam logic [31:0]        RST_INV_BIN_VOLUME = 32'd65536;
	localparam logic [31:0]        RST_UNIT_FACTOR    = 32'd65536;

	localparam logic [64:0] MAG_CAP   = 65'h0_8000_0000_0000_0000;
	localparam logic [63:0] POS_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MIN   = 64'h8000_0000_0000_0000;
	localparam logic [63:0] HI_LIMIT  = 64'h0000_8000_0000_0000;
	localparam logic [63:0] DENS_LIM  = 64'h0000_7FFF_FFFF_FFFF;

	typedef struct packed {
		logic signed [31:0] z_min;
		logic signed [31:0] z_max;
		logic [30:0]        z_pitch;
		logic [31:0]        inv_area;
		logic [31:0]        inv_bin_volume;
		logic [31:0]        unit_factor;
	} cfg_t;

	typedef struct packed {
		logic signed [63:0] normal;
		logic signed [63:0] tang;
		logic [31:0]        count;
	} bin_row_t;

	typedef struct packed {
		logic signed [31:0] bin_center;
		logic [62:0]        density;
		logic signed [63:0] normal_pressure;
		logic signed [63:0] tangential_pressure;
		logic               last_bin;
	} result_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_DSTART,
		ST_DIVW,
		ST_TLO,
		ST_THI,
		ST_TSAT,
		ST_SW_RD,
		ST_SW_WR,
		ST_AT_RD,
		ST_AT_WR,
		ST_EM_RD,
		ST_EM_DEN,
		ST_MQ_LO,
		ST_MQ_HI,
		ST_MQ_C,
		ST_EM_OUT
	} state_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] x);
		return x[63] ? (~x + 64'd1) : x;
	endfunction

	function automatic logic signed [63:0] sat_mag(input logic [64:0] mag, input logic neg);
		logic signed [63:0] r;
		if (neg) begin
			r = (mag >= MAG_CAP) ? NEG_MIN : (~mag[63:0] + 64'd1);
		end else begin
			r = (mag > {1'b0, POS_MAX}) ? POS_MAX : mag[63:0];
		end
		return r;
	endfunction

	function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [64:0] s;
		logic signed [63:0] r;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			r = s[64] ? NEG_MIN : POS_MAX;
		end else begin
			r = s[63:0];
		end
		return r;
	endfunction

	function automatic logic signed [63:0] halve(input logic signed [63:0] x);
		logic [63:0] m;
		m = mag64(x) >> 1;
		return x[63] ? (~m + 64'd1) : m;
	endfunction

	// Combines the two partial products of a Q32.32 by Q16.16 multiply.
	function automatic logic signed [63:0] mq_comb(input logic [63:0] t,
			input logic [63:0] lop, input logic neg);
		logic [64:0] r;
		if (t > HI_LIMIT) begin
			r = MAG_CAP;
		end else begin
			r = {1'b0, t[47:0], 16'b0} + {17'b0, lop[63:16]};
		end
		return sat_mag(r, neg);
	endfunction

endpackage

// ===== rtl/ppb_ram.sv =====
// ----------------------------------------------------------------------------
// ppb_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ppb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/ppb_div.sv =====
// ----------------------------------------------------------------------------
// ppb_div
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one quotient
// bit per cycle. Done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module ppb_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);

	logic [6:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic [31:0] dsr_q;
	logic [32:0] shifted;
	logic [32:0] diff;
	logic        ge;

	assign shifted = {rem_q, quo_q[63]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign ge      = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 7'd64;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[31:0] : shifted[31:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/ppb_core.sv =====
// ----------------------------------------------------------------------------
// ppb_core
// Sequencer of the binner: decodes items, drives the shared multiplier and
// divider, and reads, modifies and writes back bin rows in the bin RAM.
// ----------------------------------------------------------------------------
module ppb_core #(
	parameter int NUM_BINS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ppb_pkg::cfg_t       cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          operation,
	input  logic signed [31:0]  z_first,
	input  logic signed [31:0]  z_second,
	input  logic signed [31:0]  delta_x,
	input  logic signed [31:0]  delta_y,
	input  logic signed [31:0]  force_over_r,
	output logic                res_valid,
	output ppb_pkg::result_t    res,
	input  logic                res_take
);

	import ppb_pkg::*;

	localparam int IDXW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int CW = IDXW + 34;
	localparam int ROWW = $bits(bin_row_t);
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NUM_BINS - 1);

	state_t state_q, state_d;

	op_t                op_q;
	logic signed [31:0] z1_q, lo_q, hi_q;
	logic [31:0]        dxm_q, dym_q, adz_q, af_q;
	logic               neg_q;
	logic [63:0]        sq_q, tlo_q, lop_q, mul_p;
	logic signed [63:0] pn_q, pt_q, acc_q, pno_q, pto_q;
	logic [62:0]        dens_q;
	logic [IDXW-1:0]    idx_q;
	logic signed [CW-1:0] center_q;
	logic [NUM_BINS-1:0] vld_q;
	logic               rd_vld_s1;
	bin_row_t           row_q;
	logic [1:0]         step_q;

	logic               in_fire;
	logic signed [32:0] zd;
	logic signed [31:0] lo_in, hi_in;
	logic [30:0]        w_eff;
	logic signed [CW-1:0] w_x, lo_x, hi_x, center_init;
	logic               in_range;
	logic               mul_en;
	logic [31:0]        mul_a, mul_b;
	logic               div_start, div_done;
	logic [63:0]        div_dividend, quotient;
	logic [31:0]        div_divisor;
	logic               ram_we, ram_re;
	bin_row_t           ram_wdata;
	logic [ROWW-1:0]    ram_rdata;
	bin_row_t           row_cur;
	logic signed [63:0] a_sel;
	logic [63:0]        a_mag;
	logic [31:0]        b_sel;
	logic signed [63:0] mq_r;
	logic [64:0]        tsum;
	logic [IDXW-1:0]    atom_idx;
	logic               is_last;

	assign in_fire = in_valid && in_ready;
	assign zd      = {z_first[31], z_first} - {z_second[31], z_second};
	assign lo_in   = (z_first < z_second) ? z_first : z_second;
	assign hi_in   = (z_first < z_second) ? z_second : z_first;
	assign w_eff   = (cfg.z_pitch == '0) ? 31'd1 : cfg.z_pitch;
	assign w_x     = {{(CW - 31){1'b0}}, w_eff};
	assign lo_x    = {{(CW - 32){lo_q[31]}}, lo_q};
	assign hi_x    = {{(CW - 32){hi_q[31]}}, hi_q};
	assign center_init = {{(CW - 32){cfg.z_min[31]}}, cfg.z_min}
		+ {{(CW - 30){1'b0}}, w_eff[30:1]};
	assign in_range = (center_q > lo_x) && (center_q < hi_x);
	assign is_last  = (idx_q == LAST_IDX);
	assign atom_idx = (quotient > 64'(NUM_BINS - 1)) ? LAST_IDX : quotient[IDXW-1:0];

	assign row_cur = rd_vld_s1 ? bin_row_t'(ram_rdata) : '0;

	assign a_sel = (step_q == 2'd0) ? row_q.normal :
		(step_q == 2'd2) ? row_q.tang : acc_q;
	assign a_mag = mag64(a_sel);
	assign b_sel = step_q[0] ? cfg.unit_factor : cfg.inv_area;
	assign mq_r  = mq_comb(mul_p, lop_q, a_sel[63]);
	assign tsum  = {1'b0, mul_p[31:0], 32'b0} + {1'b0, tlo_q};

	ppb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	ppb_ram #(
		.WIDTH (ROWW),
		.DEPTH (NUM_BINS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					unique case (op_t'(operation))
						OP_CLEAR: state_d = ST_IDLE;
						OP_ATOM: begin
							if (z_first > cfg.z_max || z_first < cfg.z_min) begin
								state_d = ST_IDLE;
							end else begin
								state_d = ST_DSTART;
							end
						end
						OP_PAIR: begin
							if (lo_in > cfg.z_max || hi_in < cfg.z_min || zd == '0) begin
								state_d = ST_IDLE;
							end else begin
								state_d = ST_SQX;
							end
						end
						OP_EMIT: state_d = ST_EM_RD;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SQX:    state_d = ST_SQY;
			ST_SQY:    state_d = ST_DSTART;
			ST_DSTART: state_d = ST_DIVW;
			ST_DIVW: begin
				if (div_done) begin
					state_d = (op_q == OP_ATOM) ? ST_AT_RD : ST_TLO;
				end
			end
			ST_TLO:    state_d = ST_THI;
			ST_THI:    state_d = ST_TSAT;
			ST_TSAT:   state_d = ST_SW_RD;
			ST_SW_RD:  state_d = ST_SW_WR;
			ST_SW_WR:  state_d = is_last ? ST_IDLE : ST_SW_RD;
			ST_AT_RD:  state_d = ST_AT_WR;
			ST_AT_WR:  state_d = ST_IDLE;
			ST_EM_RD:  state_d = ST_EM_DEN;
			ST_EM_DEN: state_d = ST_MQ_LO;
			ST_MQ_LO:  state_d = ST_MQ_HI;
			ST_MQ_HI:  state_d = ST_MQ_C;
			ST_MQ_C:   state_d = (step_q == 2'd3) ? ST_EM_OUT : ST_MQ_LO;
			ST_EM_OUT: begin
				if (res_take) begin
					state_d = is_last ? ST_IDLE : ST_EM_RD;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		res_valid    = (state_q == ST_EM_OUT);
		mul_en       = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		div_start    = 1'b0;
		div_dividend = sq_q + mul_p;
		div_divisor  = adz_q;
		ram_we       = 1'b0;
		ram_re       = 1'b0;
		ram_wdata    = row_cur;
		unique case (state_q)
			ST_SQX: begin
				mul_en = 1'b1;
				mul_a  = dxm_q;
				mul_b  = dxm_q;
			end
			ST_SQY: begin
				mul_en = 1'b1;
				mul_a  = dym_q;
				mul_b  = dym_q;
			end
			ST_DSTART: begin
				div_start = 1'b1;
				mul_en    = 1'b1;
				mul_a     = adz_q;
				mul_b     = af_q;
				if (op_q == OP_ATOM) begin
					div_dividend = {32'b0, 32'(z1_q - cfg.z_min)};
					div_divisor  = {1'b0, w_eff};
				end
			end
			ST_TLO: begin
				mul_en = 1'b1;
				mul_a  = quotient[31:0];
				mul_b  = af_q;
			end
			ST_THI: begin
				mul_en = 1'b1;
				mul_a  = quotient[63:32];
				mul_b  = af_q;
			end
			ST_SW_RD, ST_AT_RD, ST_EM_RD: begin
				ram_re = 1'b1;
			end
			ST_SW_WR: begin
				ram_we           = in_range;
				ram_wdata.normal = add_sat(row_cur.normal, pn_q);
				ram_wdata.tang   = add_sat(row_cur.tang, pt_q);
			end
			ST_AT_WR: begin
				ram_we = 1'b1;
				if (row_cur.count != 32'hFFFF_FFFF) begin
					ram_wdata.count = row_cur.count + 32'd1;
				end
			end
			ST_EM_DEN: begin
				mul_en = 1'b1;
				mul_a  = row_cur.count;
				mul_b  = cfg.inv_bin_volume;
			end
			ST_MQ_LO: begin
				mul_en = 1'b1;
				mul_a  = a_mag[31:0];
				mul_b  = b_sel;
			end
			ST_MQ_HI: begin
				mul_en = 1'b1;
				mul_a  = a_mag[63:32];
				mul_b  = b_sel;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		res.bin_center = center_q[31:0];
		if (center_q > $signed({{(CW - 32){1'b0}}, 32'h7FFF_FFFF})) begin
			res.bin_center = 32'h7FFF_FFFF;
		end else if (center_q < $signed({{(CW - 32){1'b1}}, 32'h8000_0000})) begin
			res.bin_center = 32'h8000_0000;
		end
		res.density             = dens_q;
		res.normal_pressure     = pno_q;
		res.tangential_pressure = pto_q;
		res.last_bin            = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire && op_t'(operation) == OP_CLEAR) begin
				vld_q <= '0;
			end else if (ram_we) begin
				vld_q[idx_q] <= 1'b1;
			end
			if (ram_re) begin
				rd_vld_s1 <= vld_q[idx_q];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			mul_p <= mul_a * mul_b;
		end
		if (in_fire) begin
			op_q     <= op_t'(operation);
			z1_q     <= z_first;
			lo_q     <= lo_in;
			hi_q     <= hi_in;
			dxm_q    <= mag32(delta_x);
			dym_q    <= mag32(delta_y);
			af_q     <= mag32(force_over_r);
			neg_q    <= force_over_r[31];
			adz_q    <= zd[32] ? 32'(-zd) : zd[31:0];
			idx_q    <= '0;
			center_q <= center_init;
		end
		unique case (state_q)
			ST_SQY: sq_q <= mul_p;
			ST_DIVW: begin
				if (div_done && op_q == OP_ATOM) begin
					idx_q <= atom_idx;
				end
			end
			ST_TLO: pn_q <= sat_mag({1'b0, mul_p}, neg_q);
			ST_THI: tlo_q <= mul_p;
			ST_TSAT: begin
				if (mul_p[63:32] != '0) begin
					pt_q <= sat_mag(MAG_CAP, neg_q);
				end else begin
					pt_q <= sat_mag(tsum, neg_q);
				end
			end
			ST_SW_WR: begin
				idx_q    <= idx_q + IDXW'(1);
				center_q <= center_q + w_x;
			end
			ST_EM_DEN: begin
				row_q  <= row_cur;
				step_q <= 2'd0;
			end
			ST_MQ_LO: begin
				if (step_q == 2'd0) begin
					dens_q <= (mul_p > DENS_LIM) ? '1 : {mul_p[46:0], 16'b0};
				end
			end
			ST_MQ_HI: lop_q <= mul_p;
			ST_MQ_C: begin
				case (step_q)
					2'd0: acc_q <= mq_r;
					2'd1: pno_q <= mq_r;
					2'd2: acc_q <= halve(mq_r);
					default: pto_q <= mq_r;
				endcase
				step_q <= step_q + 2'd1;
			end
			ST_EM_OUT: begin
				if (res_take) begin
					idx_q    <= idx_q + IDXW'(1);
					center_q <= center_q + w_x;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/planar_pressure_profile_binner_unit.sv =====
// ----------------------------------------------------------------------------
// planar_pressure_profile_binner_unit
// Slab pressure profile along z: per-bin atom counts and normal and tangential
// pair contributions, held in one bin RAM and streamed out on request.
// ----------------------------------------------------------------------------
// Usage: items arrive on the in_ channel (valid/ready) and each carries an
// operation. Results leave on the out_ channel (valid/ready), one beat per
// bin, bin 0 first, last_bin set on the final beat; only emit items return
// beats. Registers are written through wr_en/wr_index/wr_data, and the user
// must write them only while idle; the block itself does not enforce this.
// Work per item: a binned atom runs the bit-serial divider, then a RAM read
// and write; a pair runs two squaring multiplies and the divide, then one
// read-modify-write for every bin; an emit runs the single shared 32x32
// multiplier nine times per bin. Reset clears the bins at once through
// per-bin valid bits, so no clearing pass runs. A stalled receiver holds
// the current beat in the output register; the sweep waits behind it, and a
// new item is taken as soon as the sweep finishes, even while the last beat
// is still waiting.
// ----------------------------------------------------------------------------
module planar_pressure_profile_binner_unit #(
	parameter int NUM_BINS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [31:0]        wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic signed [31:0] z_first,
	input  logic signed [31:0] z_second,
	input  logic signed [31:0] delta_x,
	input  logic signed [31:0] delta_y,
	input  logic signed [31:0] force_over_r,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] bin_center,
	output logic [62:0]        density,
	output logic signed [63:0] normal_pressure,
	output logic signed [63:0] tangential_pressure,
	output logic               last_bin
);

	import ppb_pkg::*;

	cfg_t    cfg_q;
	logic    res_valid;
	logic    res_take;
	result_t res;
	result_t out_q;
	logic    out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.z_min          <= RST_Z_MIN;
			cfg_q.z_max          <= RST_Z_MAX;
			cfg_q.z_pitch        <= RST_Z_PITCH;
			cfg_q.inv_area       <= RST_INV_AREA;
			cfg_q.inv_bin_volume <= RST_INV_BIN_VOLUME;
			cfg_q.unit_factor    <= RST_UNIT_FACTOR;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_Z_MIN:          cfg_q.z_min          <= wr_data;
				REG_Z_MAX:          cfg_q.z_max          <= wr_data;
				REG_Z_PITCH:        cfg_q.z_pitch        <= wr_data[30:0];
				REG_INV_AREA:       cfg_q.inv_area       <= wr_data;
				REG_INV_BIN_VOLUME: cfg_q.inv_bin_volume <= wr_data;
				REG_UNIT_FACTOR:    cfg_q.unit_factor    <= wr_data;
				default: begin
				end
			endcase
		end
	end

	ppb_core #(
		.NUM_BINS (NUM_BINS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.z_first      (z_first),
		.z_second     (z_second),
		.delta_x      (delta_x),
		.delta_y      (delta_y),
		.force_over_r (force_over_r),
		.res_valid    (res_valid),
		.res          (res),
		.res_take     (res_take)
	);

	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid           = out_valid_q;
	assign bin_center          = out_q.bin_center;
	assign density             = out_q.density;
	assign normal_pressure     = out_q.normal_pressure;
	assign tangential_pressure = out_q.tangential_pressure;
	assign last_bin            = out_q.last_bin;

`ifndef SYNTHESIS
	a_busy_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !in_ready)
		else $error("input taken while a result beat is pending");

	a_emit_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && operation == OP_EMIT) |=> !in_ready)
		else $error("emit item did not start a sweep");

	a_clear_single_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && operation == OP_CLEAR) |=> in_ready)
		else $error("clear item did not complete in one cycle");
`endif

endmodule

// ===== test/planar_pressure_profile_binner_unit_test.sv =====
// ----------------------------------------------------------------------------
// planar_pressure_profile_binner_unit_test
// Self-checking bench for the planar pressure profile binner. An internal
// profile predictor tracks the atom counts and the normal and tangential sums.
// Every emitted bin beat is checked field by field against the predicted
// profile, under directed items, several register settings and random traffic.
// ----------------------------------------------------------------------------
module planar_pressure_profile_binner_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ppb_pkg::*;

	localparam int NBINS = 64;
	localparam int CYCLE_LIMIT = 3000000;
	localparam longint SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint SMIN = 64'sh8000_0000_0000_0000;
	localparam longint unsigned UCAP = 64'h8000_0000_0000_0000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               wr_en = 1'b0;
	logic [2:0]         wr_index = '0;
	logic [31:0]        wr_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         operation = '0;
	logic signed [31:0] z_first = '0;
	logic signed [31:0] z_second = '0;
	logic signed [31:0] delta_x = '0;
	logic signed [31:0] delta_y = '0;
	logic signed [31:0] force_over_r = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] bin_center;
	logic [62:0]        density;
	logic signed [63:0] normal_pressure;
	logic signed [63:0] tangential_pressure;
	logic               last_bin;

	planar_pressure_profile_binner_unit DUT (.*);

	always #4 clk = ~clk;

	longint          slab_lo, slab_hi, width_raw;
	longint unsigned area_inv, vol_inv, unit_mul;
	longint          normal_acc [NBINS];
	longint          tang_acc [NBINS];
	int unsigned     atom_cnt [NBINS];
	result_t         profile_beats_q [$];
	int              errors = 0;
	int              cycles = 0;
	bit              quiet = 1'b0;
	bit              hold_request = 1'b0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("planar_pressure_profile_binner_unit_test: FAIL");
			$finish;
		end
	end

	function automatic longint sat_mag(longint unsigned m, bit neg);
		if (neg)
			return (m >= UCAP) ? SMIN : -longint'(m);
		return (m > 64'h7FFF_FFFF_FFFF_FFFF) ? SMAX : longint'(m);
	endfunction

	function automatic longint unsigned abs64(longint a);
		return (a < 0) ? 64'd0 - longint'(a) : longint'(a);
	endfunction

	function automatic longint add_sat64(longint a, longint b);
		if (b > 0 && a > SMAX - b) return SMAX;
		if (b < 0 && a < SMIN - b) return SMIN;
		return a + b;
	endfunction

	function automatic longint scale_q16(longint a, longint unsigned b);
		longint unsigned m, hi, lo, t, r;
		m = abs64(a);
		hi = m >> 32;
		lo = m & 64'hFFFF_FFFF;
		t = hi * b;
		if (t > 64'h0000_8000_0000_0000) return sat_mag(UCAP, a < 0);
		r = (t << 16) + ((lo * b) >> 16);
		if (r > UCAP) r = UCAP;
		return sat_mag(r, a < 0);
	endfunction

	function automatic longint eff_width();
		return (width_raw == 0) ? 64'sd1 : width_raw;
	endfunction

	function automatic longint centre_at(int i);
		return slab_lo + longint'(i) * eff_width() + (eff_width() >>> 1);
	endfunction

	task automatic predict_item(op_t op, longint z1, longint z2, longint dx, longint dy,
			longint f);
		longint lo, hi, pn, pt, c;
		longint unsigned adz, af, q, tm, idx, p;
		result_t beat;
		case (op)
			OP_CLEAR: begin
				foreach (atom_cnt[i]) begin
					normal_acc[i] = 0;
					tang_acc[i] = 0;
					atom_cnt[i] = 0;
				end
			end
			OP_ATOM: begin
				if (!(z1 > slab_hi || z1 < slab_lo)) begin
					idx = longint'(z1 - slab_lo) / longint'(eff_width());
					if (idx > NBINS - 1) idx = NBINS - 1;
					if (atom_cnt[idx] != 32'hFFFF_FFFF) atom_cnt[idx]++;
				end
			end
			OP_PAIR: begin
				lo = (z1 < z2) ? z1 : z2;
				hi = (z1 < z2) ? z2 : z1;
				adz = abs64(z1 - z2);
				af = abs64(f);
				if (!(lo > slab_hi || hi < slab_lo || adz == 0)) begin
					pn = sat_mag(adz * af, f < 0);
					q = (longint'(dx * dx) + longint'(dy * dy)) / adz;
					tm = (af != 0 && q > UCAP / af) ? UCAP : q * af;
					pt = sat_mag(tm, f < 0);
					for (int i = 0; i < NBINS; i++) begin
						c = centre_at(i);
						if (c > lo && c < hi) begin
							normal_acc[i] = add_sat64(normal_acc[i], pn);
							tang_acc[i] = add_sat64(tang_acc[i], pt);
						end
					end
				end
			end
			OP_EMIT: begin
				for (int i = 0; i < NBINS; i++) begin
					c = centre_at(i);
					if (c > 64'sd2147483647) c = 64'sd2147483647;
					if (c < -64'sd2147483648) c = -64'sd2147483648;
					p = longint'(atom_cnt[i]) * vol_inv;
					pn = scale_q16(scale_q16(normal_acc[i], area_inv), unit_mul);
					pt = scale_q16(tang_acc[i], area_inv);
					pt = sat_mag(abs64(pt) >> 1, pt < 0);
					pt = scale_q16(pt, unit_mul);
					beat.bin_center = c[31:0];
					beat.density = (p > 64'h0000_7FFF_FFFF_FFFF) ? {63{1'b1}} : p[46:0] << 16;
					beat.normal_pressure = pn;
					beat.tangential_pressure = pt;
					beat.last_bin = (i == NBINS - 1);
					profile_beats_q.push_back(beat);
				end
			end
		endcase
	endtask

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					out_ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (profile_beats_q.size() == 0) begin
				$error("unexpected beat: bin_center %0d", bin_center);
				errors++;
			end else begin
				want = profile_beats_q.pop_front();
				if (bin_center !== want.bin_center) begin
					$error("bin_center: expected %0d, got %0d", want.bin_center, bin_center);
					errors++;
				end
				if (density !== want.density) begin
					$error("density: expected %0h, got %0h", want.density, density);
					errors++;
				end
				if (normal_pressure !== want.normal_pressure) begin
					$error("normal_pressure: expected %0h, got %0h", want.normal_pressure,
						normal_pressure);
					errors++;
				end
				if (tangential_pressure !== want.tangential_pressure) begin
					$error("tangential_pressure: expected %0h, got %0h",
						want.tangential_pressure, tangential_pressure);
					errors++;
				end
				if (last_bin !== want.last_bin) begin
					$error("last_bin: expected %0b, got %0b", want.last_bin, last_bin);
					errors++;
				end
			end
		end
	end

	task automatic send_item(op_t op, logic signed [31:0] z1, logic signed [31:0] z2,
			logic signed [31:0] dx, logic signed [31:0] dy, logic signed [31:0] f);
		int gap;
		in_valid <= 1'b1;
		operation <= op;
		z_first <= z1;
		z_second <= z2;
		delta_x <= dx;
		delta_y <= dy;
		force_over_r <= f;
		do @(posedge clk); while (!in_ready);
		predict_item(op, z1, z2, dx, dy, f);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (profile_beats_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_Z_MIN:          slab_lo = longint'(signed'(value));
			REG_Z_MAX:          slab_hi = longint'(signed'(value));
			REG_Z_PITCH:        width_raw = longint'(value[30:0]);
			REG_INV_AREA:       area_inv = value;
			REG_INV_BIN_VOLUME: vol_inv = value;
			REG_UNIT_FACTOR:    unit_mul = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_z();
		longint base, z;
		if ($urandom_range(0, 9) < 2) return $urandom;
		base = (slab_lo < slab_hi) ? slab_lo : slab_hi;
		z = base - eff_width() + longint'($urandom_range(0, 66 * 1024)) * eff_width() / 1024;
		if (z > 64'sd2147483647) z = 64'sd2147483647;
		if (z < -64'sd2147483648) z = -64'sd2147483648;
		return z[31:0];
	endfunction

	function automatic logic signed [31:0] rand_small();
		if ($urandom_range(0, 9) < 2) return $urandom;
		return $signed($urandom_range(0, 524288)) - 262144;
	endfunction

	task automatic send_random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 2)
			send_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
		else if (r < 38)
			send_item(OP_ATOM, rand_z(), $urandom, $urandom, $urandom, $urandom);
		else if (r < 93)
			send_item(OP_PAIR, rand_z(), rand_z(), rand_small(), rand_small(), rand_small());
		else
			send_item(OP_EMIT, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic test_directed();
		send_item(OP_CLEAR, 0, 0, 0, 0, 0);
		send_item(OP_ATOM, 0, 0, 0, 0, 0);
		send_item(OP_ATOM, 32'sd4194304, 0, 0, 0, 0);
		send_item(OP_ATOM, -32'sd1, 0, 0, 0, 0);
		send_item(OP_ATOM, 32'sd4194305, 0, 0, 0, 0);
		send_item(OP_ATOM, 32'sh7FFF_FFFF, 0, 0, 0, 0);
		send_item(OP_ATOM, 32'sh8000_0000, 0, 0, 0, 0);
		send_item(OP_ATOM, 32'sd65536, 0, 0, 0, 0);
		send_item(OP_PAIR, 32'sd98304, 32'sd98304, 32'sd65536, 32'sd65536, 32'sd65536);
		send_item(OP_PAIR, 32'sd16384, 32'sd704512, 32'sd65536, 32'sd131072, 32'sd65536);
		send_item(OP_PAIR, 32'sd704512, 32'sd16384, -32'sd65536, 32'sd0, -32'sd196608);
		send_item(OP_PAIR, 0, 32'sd4194304, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh8000_0000);
		send_item(OP_PAIR, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0,
			32'sh7FFF_FFFF);
		send_item(OP_PAIR, 32'sd4194400, 32'sd5000000, 32'sd65536, 0, 32'sd65536);
		send_item(OP_PAIR, -32'sd10, -32'sd1000, 32'sd65536, 0, 32'sd65536);
		send_item(OP_PAIR, 32'sd32767, 32'sd32769, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh7FFF_FFFF);
		send_item(OP_EMIT, 0, 0, 0, 0, 0);
		send_item(OP_CLEAR, 0, 0, 0, 0, 0);
		send_item(OP_EMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF);
	endtask

	task automatic test_setting(logic [31:0] lo, logic [31:0] hi, logic [31:0] w,
			logic [31:0] ia, logic [31:0] ibv, logic [31:0] uf, int count, bit no_idle);
		wait_drained();
		write_reg(REG_Z_MIN, lo);
		write_reg(REG_Z_MAX, hi);
		write_reg(REG_Z_PITCH, w);
		write_reg(REG_INV_AREA, ia);
		write_reg(REG_INV_BIN_VOLUME, ibv);
		write_reg(REG_UNIT_FACTOR, uf);
		quiet = no_idle;
		repeat (count) send_random_item();
		send_item(OP_EMIT, 0, 0, 0, 0, 0);
		quiet = 1'b0;
	endtask

	task automatic test_backpressure();
		wait_drained();
		hold_request = 1'b1;
		quiet = 1'b1;
		repeat (3) send_item(OP_EMIT, 0, 0, 0, 0, 0);
		send_item(OP_PAIR, rand_z(), rand_z(), rand_small(), rand_small(), rand_small());
		quiet = 1'b0;
		wait_drained();
		send_item(OP_EMIT, 0, 0, 0, 0, 0);
	endtask

	initial begin
		slab_lo = RST_Z_MIN;
		slab_hi = RST_Z_MAX;
		width_raw = RST_Z_PITCH;
		area_inv = RST_INV_AREA;
		vol_inv = RST_INV_BIN_VOLUME;
		unit_mul = RST_UNIT_FACTOR;
		foreach (atom_cnt[i]) begin
			normal_acc[i] = 0;
			tang_acc[i] = 0;
			atom_cnt[i] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_setting(32'd0, 32'd4194304, 32'd65536, 32'd65536, 32'd65536, 32'd65536, 50, 0);
		test_setting(-32'sd524288, 32'sd524288, 32'd16384, 32'd32768, 32'd196608,
			32'd163840, 40, 1);
		test_setting(-32'sd100, 32'sd100, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 30, 0);
		test_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd1, 32'd0, 20, 0);
		test_setting(32'sd655360, -32'sd655360, 32'd65536, 32'd65536, 32'd65536,
			32'd65536, 20, 0);
		test_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'h0400_0000, $urandom, $urandom,
			$urandom, 40, 0);
		wait_drained();
		if (errors == 0) begin
			$display("planar_pressure_profile_binner_unit_test: PASS");
		end else begin
			$display("planar_pressure_profile_binner_unit_test: FAIL");
		end
		$finish;
	end

endmodule
